// ===== src/ipfl_pkg.sv =====
// Shared constants, codes and types for the indexed pool free-list allocator.
// No dependencies; every module of the block imports this package.
package ipfl_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int TYPE_BITS  = 32;
    localparam int SLOT_W     = $clog2(POOL_DEPTH);
    localparam int PTR_W      = SLOT_W + 1;
    localparam int CAP_W      = 9;
    localparam int FUNC_W     = 2;
    localparam int CODE_W     = 2;
    localparam int IO_TYPE_W  = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CREATE  = 2'd0,
        FUNC_DESTROY = 2'd1,
        FUNC_GET     = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef enum logic [CODE_W-1:0] {
        CODE_OK          = 2'd0,
        CODE_FULL        = 2'd1,
        CODE_DOUBLE_FREE = 2'd2,
        CODE_BAD_INDEX   = 2'd3
    } code_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic                 nf_we;
        logic [SLOT_W-1:0]    nf_addr;
        logic [PTR_W-1:0]     nf_data;
        logic                 ty_we;
        logic [SLOT_W-1:0]    ty_addr;
        logic [TYPE_BITS-1:0] ty_data;
        logic                 al_we;
        logic [SLOT_W-1:0]    al_addr;
        logic                 al_data;
    } ipfl_wr_t;

endpackage

// ===== src/ipfl_mem.sv =====
// Link, type and alive storage: three synchronous memories, one write and one read port each.
// Depends on ipfl_pkg for widths and the write-control struct.
module ipfl_mem
    import ipfl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rd_en,
    input  logic [SLOT_W-1:0]    nf_raddr,
    input  logic [SLOT_W-1:0]    ty_raddr,
    input  logic [SLOT_W-1:0]    al_raddr,
    input  ipfl_wr_t             wr,
    output logic [PTR_W-1:0]     nf_rdata,
    output logic [TYPE_BITS-1:0] ty_rdata,
    output logic                 al_rdata
);

    logic [PTR_W-1:0]     next_free_mem [POOL_DEPTH];
    logic [TYPE_BITS-1:0] slot_type_mem [POOL_DEPTH];
    logic                 alive_mem [POOL_DEPTH];
    logic [PTR_W-1:0]     nf_rdata_reg;
    logic [TYPE_BITS-1:0] ty_rdata_reg;
    logic                 al_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.nf_we)
        begin
            next_free_mem[wr.nf_addr] <= wr.nf_data;
        end
        if (rd_en)
        begin
            nf_rdata_reg <= next_free_mem[nf_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.ty_we)
        begin
            slot_type_mem[wr.ty_addr] <= wr.ty_data;
        end
        if (rd_en)
        begin
            ty_rdata_reg <= slot_type_mem[ty_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.al_we)
        begin
            alive_mem[wr.al_addr] <= wr.al_data;
        end
        if (rd_en)
        begin
            al_rdata_reg <= alive_mem[al_raddr];
        end
    end

    assign nf_rdata = nf_rdata_reg;
    assign ty_rdata = ty_rdata_reg;
    assign al_rdata = al_rdata_reg;

endmodule

// ===== src/indexed_pool_free_list.sv =====
// Slot allocator over a fixed pool with a free list threaded through the slots.
// The request is taken in ST_IDLE; its result enters the output register at the ST_EXEC commit.
// A new request is stalled until the previous one commits; the read of the link, type and
// alive memories comes before the read-modify-write commit, and a stalled output holds it.
// Reset: rst_n asynchronous, sets head, high-water mark and live count to 1, sets capacity
// to 256; memories are not cleared, entries at or above the high-water mark are never used.
module indexed_pool_free_list
    import ipfl_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [FUNC_W-1:0]     func,
    input  logic [SLOT_W-1:0]     slot,
    input  logic [IO_TYPE_W-1:0]  entry_type,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [CODE_W-1:0]     code,
    output logic [SLOT_W-1:0]     slot_out,
    output logic                  alive,
    output logic [IO_TYPE_W-1:0]  type_out,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CAP_W-1:0]      cfg_data
);

    state_t               state_reg, state_next;
    logic [CAP_W-1:0]     capacity_reg;
    logic [PTR_W-1:0]     free_head_reg, free_head_next;
    logic [PTR_W-1:0]     high_water_reg, high_water_next;
    logic [PTR_W-1:0]     live_count_reg, live_count_next;

    func_t                op_func_reg;
    logic [SLOT_W-1:0]    op_slot_reg;
    logic [TYPE_BITS-1:0] op_type_reg;

    logic                 out_valid_reg, out_valid_next;
    code_t                code_reg, code_next;
    logic [SLOT_W-1:0]    slot_out_reg, slot_out_next;
    logic                 alive_out_reg, alive_out_next;
    logic [IO_TYPE_W-1:0] type_out_reg, type_out_next;

    logic                 accept;
    logic                 commit;
    logic                 out_free;
    logic [PTR_W-1:0]     cap_eff;
    logic [SLOT_W-1:0]    head_idx;
    logic                 create_full;
    logic                 index_ok;
    ipfl_wr_t             wr;
    logic [PTR_W-1:0]     nf_rdata;
    logic [TYPE_BITS-1:0] ty_rdata;
    logic                 al_rdata;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;
    assign commit    = (state_reg == ST_EXEC) && out_free;
    assign head_idx  = free_head_reg[SLOT_W-1:0];

    assign cap_eff = (PTR_W'(capacity_reg) > PTR_W'(POOL_DEPTH)) ?
                     PTR_W'(POOL_DEPTH) : PTR_W'(capacity_reg);
    assign create_full = (live_count_reg >= cap_eff) ||
                         (free_head_reg >= PTR_W'(POOL_DEPTH));
    assign index_ok = (op_slot_reg != '0) && (PTR_W'(op_slot_reg) < high_water_reg);

    ipfl_mem u_mem (
        .clk      (clk),
        .rd_en    (accept),
        .nf_raddr (free_head_reg[SLOT_W-1:0]),
        .ty_raddr (slot),
        .al_raddr (slot),
        .wr       (wr),
        .nf_rdata (nf_rdata),
        .ty_rdata (ty_rdata),
        .al_rdata (al_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        high_water_next = high_water_reg;
        live_count_next = live_count_reg;
        out_valid_next  = out_valid_reg && out_stall;
        code_next       = code_reg;
        slot_out_next   = slot_out_reg;
        alive_out_next  = alive_out_reg;
        type_out_next   = type_out_reg;
        wr              = '0;
        wr.nf_addr      = op_slot_reg;
        wr.nf_data      = free_head_reg;
        wr.ty_addr      = head_idx;
        wr.ty_data      = op_type_reg;
        wr.al_addr      = op_slot_reg;
        wr.al_data      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    code_next      = CODE_OK;
                    slot_out_next  = op_slot_reg;
                    alive_out_next = 1'b0;
                    type_out_next  = '0;
                    case (op_func_reg)
                        FUNC_CREATE:
                        begin
                            if (create_full)
                            begin
                                code_next     = CODE_FULL;
                                slot_out_next = '0;
                            end
                            else
                            begin
                                if (free_head_reg == high_water_reg)
                                begin
                                    high_water_next = high_water_reg + 1'b1;
                                    free_head_next  = free_head_reg + 1'b1;
                                end
                                else
                                begin
                                    free_head_next = nf_rdata;
                                end
                                live_count_next = live_count_reg + 1'b1;
                                wr.al_we        = 1'b1;
                                wr.al_addr      = head_idx;
                                wr.al_data      = 1'b1;
                                wr.ty_we        = 1'b1;
                                slot_out_next   = head_idx;
                            end
                        end
                        FUNC_DESTROY:
                        begin
                            if (!index_ok)
                            begin
                                code_next = CODE_BAD_INDEX;
                            end
                            else if (!al_rdata)
                            begin
                                code_next = CODE_DOUBLE_FREE;
                            end
                            else
                            begin
                                wr.al_we        = 1'b1;
                                wr.nf_we        = 1'b1;
                                free_head_next  = PTR_W'(op_slot_reg);
                                live_count_next = live_count_reg - 1'b1;
                            end
                        end
                        FUNC_GET:
                        begin
                            if (!index_ok)
                            begin
                                code_next = CODE_BAD_INDEX;
                            end
                            else
                            begin
                                alive_out_next = al_rdata;
                                type_out_next  = IO_TYPE_W'(ty_rdata);
                            end
                        end
                        default:
                        begin
                            code_next = CODE_BAD_INDEX;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            capacity_reg   <= CAP_W'(POOL_DEPTH);
            free_head_reg  <= PTR_W'(1);
            high_water_reg <= PTR_W'(1);
            live_count_reg <= PTR_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            high_water_reg <= high_water_next;
            live_count_reg <= live_count_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                capacity_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_func_reg <= func_t'(func);
            op_slot_reg <= slot;
            op_type_reg <= TYPE_BITS'(entry_type);
        end
        code_reg      <= code_next;
        slot_out_reg  <= slot_out_next;
        alive_out_reg <= alive_out_next;
        type_out_reg  <= type_out_next;
    end

    assign out_valid = out_valid_reg;
    assign code      = code_reg;
    assign slot_out  = slot_out_reg;
    assign alive     = alive_out_reg;
    assign type_out  = type_out_reg;

    a_live_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
        live_count_reg <= high_water_reg)
        else $error("live count passed high-water mark");

    a_head_le_hw: assert property (@(posedge clk) disable iff (!rst_n)
        free_head_reg <= high_water_reg)
        else $error("free head beyond high-water mark");

    a_create_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && op_func_reg == FUNC_CREATE && !create_full)
        |=> (out_valid_reg && code_reg == CODE_OK && slot_out_reg != '0))
        else $error("created slot not reported");

    a_get_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (commit && op_func_reg != FUNC_DESTROY) |-> !wr.nf_we)
        else $error("link written outside destroy");

endmodule
